FILE: src/sptp_pkg.sv
// Shared types and constants for the sine product test pattern generator.
// Holds the stream word structs, register indexes and fixed scaling constants.
// No dependencies.
package sptp_pkg;

    // Input word: one binned pixel position.
    typedef struct packed {
        logic [10:0] column;
        logic [10:0] row;
        logic        frame_end;
    } in_word_t;

    // Output word: one generated pixel.
    typedef struct packed {
        logic [15:0] pixel_value;
        logic        last_of_frame;
    } out_word_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_HORIZONTAL_BIN   = 3'd0;
    localparam cfg_index_t REG_VERTICAL_BIN     = 3'd1;
    localparam cfg_index_t REG_SIXTEEN_BIT_MODE = 3'd2;
    localparam cfg_index_t REG_X_PHASE_STEP     = 3'd3;
    localparam cfg_index_t REG_Y_PHASE_STEP     = 3'd4;

    // Register values after reset.
    localparam logic [4:0]  RESET_HORIZONTAL_BIN = 5'd1;
    localparam logic [4:0]  RESET_VERTICAL_BIN   = 5'd1;
    localparam logic        RESET_SIXTEEN_BIT    = 1'b1;
    localparam logic [31:0] RESET_X_PHASE_STEP   = 32'd42949673;
    localparam logic [31:0] RESET_Y_PHASE_STEP   = 32'd21474836;

    // Output scale factors for the two pixel depths.
    localparam logic [14:0] SCALE_16BIT = 15'd32767;
    localparam logic [14:0] SCALE_8BIT  = 15'd127;

    // Fixed-point constants in Q2.30, and the largest Q1.15 value.
    localparam logic [31:0]       Q30_ONE     = 32'd1073741824;
    localparam longint unsigned   Q30_ONE_L   = 64'd1073741824;
    localparam longint unsigned   Q30_HALF_PI = 64'd1686629713;
    localparam longint unsigned   Q15_MAX     = 64'd32767;

endpackage

FILE: src/sine_product_test_pattern_top.sv
// Throughput: one word per clock; each stage holds one word and a stall at the
// output backs up only the stages that are full, bubbles are squeezed out.
// The sine table is a ROM built at elaboration and read with a registered port.
// Reset (aresetn low, synchronous) empties the pipeline, clears the frame counter
// and returns every configuration register to its default.
//
// Top level of the sine product test pattern generator.
// Depends on sptp_pkg for word types, register indexes and constants.
module sine_product_test_pattern_top #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int MAX_DIMENSION    = 2048
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  sptp_pkg::in_word_t          s_data,

    output logic                        m_valid,
    input  logic                        m_ready,
    output sptp_pkg::out_word_t         m_data,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  sptp_pkg::cfg_index_t        cfg_index,
    input  logic [31:0]                 cfg_data
);

    localparam int NUM_STAGES = 7;
    localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int DEPTH_W    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KPROD_W    = 32 + DEPTH_W;
    localparam logic [31:0] DIM_LIMIT = 32'(MAX_DIMENSION - 1);
    localparam longint unsigned TABLE_DEPTH_U = 64'(SINE_TABLE_DEPTH);

    typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    // sin(pi/2 * r / depth) in Q30 by an 11th-order Taylor polynomial.
    function automatic longint unsigned quarter_sine(input longint unsigned r);
        longint unsigned xq;
        longint unsigned th;
        longint unsigned t2;
        longint unsigned acc;
        xq  = (r << 30) / TABLE_DEPTH_U;
        th  = (xq * sptp_pkg::Q30_HALF_PI) >> 30;
        t2  = (th * th) >> 30;
        acc = sptp_pkg::Q30_ONE_L;
        acc = sptp_pkg::Q30_ONE_L - ((t2 * acc) >> 30) / 110;
        acc = sptp_pkg::Q30_ONE_L - ((t2 * acc) >> 30) / 72;
        acc = sptp_pkg::Q30_ONE_L - ((t2 * acc) >> 30) / 42;
        acc = sptp_pkg::Q30_ONE_L - ((t2 * acc) >> 30) / 20;
        acc = sptp_pkg::Q30_ONE_L - ((t2 * acc) >> 30) / 6;
        return (th * acc) >> 30;
    endfunction

    // Q1.15 table entry k using quarter-wave symmetry, rounded half up.
    function automatic logic signed [15:0] sine_entry(input longint unsigned k);
        longint unsigned u;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned r;
        longint unsigned s;
        longint unsigned q;
        u    = k * 4;
        quad = (u / TABLE_DEPTH_U) & 64'd3;
        rem  = u % TABLE_DEPTH_U;
        r    = quad[0] ? (TABLE_DEPTH_U - rem) : rem;
        s    = quarter_sine(r);
        q    = (s * sptp_pkg::Q15_MAX + (64'd1 << 29)) >> 30;
        if (q > sptp_pkg::Q15_MAX) begin
            q = sptp_pkg::Q15_MAX;
        end
        return quad[1] ? -16'(q) : 16'(q);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            rom[i] = sine_entry(64'(i));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Configuration registers and frame counter.
    logic [4:0]  horizontal_bin_reg;
    logic [4:0]  vertical_bin_reg;
    logic        sixteen_bit_mode_reg;
    logic [31:0] x_phase_step_reg;
    logic [31:0] y_phase_step_reg;
    logic [31:0] frame_counter_reg;

    // Pipeline control.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] last_reg;
    logic [NUM_STAGES-1:0] stage_ready;

    // Pipeline payload.
    logic [31:0]              pos_x_reg, pos_y_reg;
    logic [31:0]              phase_x_reg, phase_y_reg;
    logic [IDX_W-1:0]         idx_x_reg, idx_y_reg;
    logic signed [15:0]       sine_x_reg, sine_y_reg;
    logic signed [31:0]       prod_reg;
    logic [31:0]              base_reg;
    logic [15:0]              pixel_reg;

    logic                     in_accept;
    logic [10:0]              column_clamped;
    logic [10:0]              row_clamped;
    logic [15:0]              column_scaled;
    logic [15:0]              row_scaled;
    logic [31:0]              pos_x_next, pos_y_next;
    logic [31:0]              phase_x_next, phase_y_next;
    logic [KPROD_W-1:0]       kprod_x, kprod_y;
    logic signed [31:0]       prod_next;
    logic [31:0]              base_next;
    logic [14:0]              scale;
    logic [46:0]              pixel_full;

    // Nothing is taken in while reset is held.
    assign cfg_ready = aresetn;
    assign in_accept = s_valid && s_ready;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            horizontal_bin_reg   <= sptp_pkg::RESET_HORIZONTAL_BIN;
            vertical_bin_reg     <= sptp_pkg::RESET_VERTICAL_BIN;
            sixteen_bit_mode_reg <= sptp_pkg::RESET_SIXTEEN_BIT;
            x_phase_step_reg     <= sptp_pkg::RESET_X_PHASE_STEP;
            y_phase_step_reg     <= sptp_pkg::RESET_Y_PHASE_STEP;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sptp_pkg::REG_HORIZONTAL_BIN:   horizontal_bin_reg   <= cfg_data[4:0];
                sptp_pkg::REG_VERTICAL_BIN:     vertical_bin_reg     <= cfg_data[4:0];
                sptp_pkg::REG_SIXTEEN_BIT_MODE: sixteen_bit_mode_reg <= cfg_data[0];
                sptp_pkg::REG_X_PHASE_STEP:     x_phase_step_reg     <= cfg_data;
                sptp_pkg::REG_Y_PHASE_STEP:     y_phase_step_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The frame counter advances once the last word of a frame is taken in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_counter_reg <= '0;
        end else if (in_accept && s_data.frame_end) begin
            frame_counter_reg <= frame_counter_reg + 32'd1;
        end
    end

    // A stage may load when it is empty or when its word moves on.
    always_comb begin
        stage_ready[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_ready[i] = !vld_reg[i] || stage_ready[i+1];
        end
    end

    assign s_ready = stage_ready[0] && aresetn;

    // Valid and end-of-frame flags travel with the words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_ready[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            last_reg[0] <= s_data.frame_end;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_ready[i]) begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    // Stage 1: clamp the coordinates, scale by the binning and add the frame count.
    always_comb begin
        column_clamped = (32'(s_data.column) > DIM_LIMIT) ? DIM_LIMIT[10:0] : s_data.column;
        row_clamped    = (32'(s_data.row) > DIM_LIMIT) ? DIM_LIMIT[10:0] : s_data.row;
        column_scaled  = 16'(column_clamped) * 16'(horizontal_bin_reg);
        row_scaled     = 16'(row_clamped) * 16'(vertical_bin_reg);
        pos_x_next     = frame_counter_reg + 32'(column_scaled);
        pos_y_next     = frame_counter_reg + 32'(row_scaled);
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    // Stage 2: phase in turns, wrapping modulo one turn.
    assign phase_x_next = pos_x_reg * x_phase_step_reg;
    assign phase_y_next = pos_y_reg * y_phase_step_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            phase_x_reg <= phase_x_next;
            phase_y_reg <= phase_y_next;
        end
    end

    // Stage 3: table index is the phase times the table depth, upper bits.
    assign kprod_x = KPROD_W'(phase_x_reg) * KPROD_W'(SINE_TABLE_DEPTH);
    assign kprod_y = KPROD_W'(phase_y_reg) * KPROD_W'(SINE_TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            idx_x_reg <= kprod_x[32+IDX_W-1:32];
            idx_y_reg <= kprod_y[32+IDX_W-1:32];
        end
    end

    // Stage 4: registered reads of the sine ROM.
    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            sine_x_reg <= SINE_ROM[idx_x_reg];
            sine_y_reg <= SINE_ROM[idx_y_reg];
        end
    end

    // Stage 5: product of the two sines in Q2.30.
    assign prod_next = 32'(sine_x_reg) * 32'(sine_y_reg);

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            prod_reg <= prod_next;
        end
    end

    // Stage 6: offset by one; the sum is never negative.
    assign base_next = sptp_pkg::Q30_ONE + unsigned'(prod_reg);

    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            base_reg <= base_next;
        end
    end

    // Stage 7: scale to the pixel depth and truncate; this is the output register.
    assign scale      = sixteen_bit_mode_reg ? sptp_pkg::SCALE_16BIT : sptp_pkg::SCALE_8BIT;
    assign pixel_full = 47'(base_reg) * 47'(scale);

    always_ff @(posedge aclk) begin
        if (stage_ready[6]) begin
            pixel_reg <= pixel_full[45:30];
        end
    end

    assign m_valid              = vld_reg[NUM_STAGES-1];
    assign m_data.pixel_value   = pixel_reg;
    assign m_data.last_of_frame = last_reg[NUM_STAGES-1];

`ifndef SYNTHESIS
    // The frame counter moves by one exactly after a word that ends a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            (frame_counter_reg == $past(frame_counter_reg)
                + (($past(in_accept) && $past(s_data.frame_end)) ? 32'd1 : 32'd0)))
        else $error("frame counter out of step with accepted frame ends");

    // A full pipeline facing a stalled output takes in nothing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_ready) |-> !s_ready)
        else $error("input taken while the pipeline is full and stalled");

    // A stalled output word keeps its pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(pixel_reg)))
        else $error("stalled output word lost or changed");

    // In 8-bit mode the pixel never exceeds twice the 8-bit scale.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !sixteen_bit_mode_reg) |-> (pixel_reg <= 16'd254))
        else $error("8-bit pixel out of range");
`endif

endmodule
